/* hw/rtl/otb_pkg.sv */
// Shared constants, widths and sequencer states for the Otsu threshold binarizer.
package otb_pkg;

  // Pixel and histogram geometry.
  localparam int PIX_W   = 8;
  localparam int BIN_W   = 4;
  localparam int BINS    = 16;
  localparam logic [BIN_W-1:0] LAST_BIN = 4'd15;

  // Counts and moments: up to 2^20 pixels, moments up to 15 * 2^20.
  localparam int CNT_W   = 21;
  localparam int MOM_W   = 24;
  localparam logic [CNT_W-1:0] MAX_PIXELS = 21'd1048576;

  // Shared multiplier: 24 x 24 bits, products of interest stay below 2^44.
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 44;
  localparam int HALF_W  = 22;

  // Square of the difference, denominator, quotient and remainder widths.
  localparam int SQ_W    = 88;
  localparam int DEN_W   = 40;
  localparam int QUO_W   = 48;
  localparam int DIVC_W  = 7;
  localparam logic [DIVC_W-1:0] DIV_LAST = 7'd87;

  // Tie tracking: sum of tied bin indexes and number of tied bins.
  localparam int SUM_W   = 7;
  localparam int TIE_W   = 5;

  // Output pixel levels.
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  // Input item kinds.
  localparam logic KIND_COUNT    = 1'b0;
  localparam logic KIND_BINARIZE = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MT,
    S_ACC,
    S_CHK,
    S_MA,
    S_MB,
    S_DIF,
    S_DEN,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_SQ3,
    S_DIV,
    S_CMP,
    S_AVG,
    S_FIN
  } otb_state_t;

endpackage

/* hw/rtl/otb_if.sv */
// Valid/ready stream interfaces for the pixel input and result output channels.
interface otb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [otb_pkg::PIX_W-1:0]   pixel;
  logic                        last;

  modport source (output valid, kind, pixel, last, input ready);
  modport sink   (input valid, kind, pixel, last, output ready);
endinterface

interface otb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_threshold;
  logic [otb_pkg::PIX_W-1:0]   threshold_level;
  logic [otb_pkg::PIX_W-1:0]   binary_pixel;

  modport source (output valid, is_threshold, threshold_level, binary_pixel, input ready);
  modport sink   (input valid, is_threshold, threshold_level, binary_pixel, output ready);
endinterface

/* hw/rtl/otsu_threshold_binarizer.sv */
// Otsu threshold binarizer: 16-bin histogram, sequenced threshold search, pixel binarizer.
//
// Usage: pixels arrive on in_ch. A count transaction (kind 0) adds the pixel to a 16-bin
// histogram and returns nothing, unless it carries last; then the block computes a new
// threshold, returns it as one out_ch transaction with is_threshold set, and clears the
// histogram. A binarize transaction (kind 1) returns 0 or 255 against the stored
// threshold, in the cycle after acceptance. Count and binarize transactions sustain one
// per cycle while out_ch keeps up. A last transaction keeps in_ch.ready low for the
// threshold computation: a pass over all bins for the total moment, then for each bin
// the cumulative sums and an empty-split check, and for a bin whose split is not empty
// the products, the square and a division; then the best bins are averaged on the
// divider and the result issued. The top bin always holds every pixel, so at most 15
// bins take the long path; the final step waits while out_ch holds off the result. The
// search uses the single shared 24x24 multiplier, which builds each product and square
// in turn, and the restoring divider, which yields one quotient bit per cycle over 88
// steps. Reset (rst_n low, synchronous) clears the histogram, the pixel total and the
// threshold. Results sit in an output register; while out_ch is stalled, a new item is
// taken only once that register drains.
module otsu_threshold_binarizer (
  input  logic          clk,
  input  logic          rst_n,
  otb_in_if.sink        in_ch,
  otb_out_if.source     out_ch
);

  // Sequencer and histogram state.
  otb_pkg::otb_state_t state_r, state_nxt;
  logic [otb_pkg::CNT_W-1:0]  bins_r [otb_pkg::BINS];
  logic [otb_pkg::CNT_W-1:0]  bins_nxt [otb_pkg::BINS];
  logic [otb_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [otb_pkg::PIX_W-1:0]  thr_r, thr_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_is_thr_r, out_is_thr_nxt;
  logic [otb_pkg::PIX_W-1:0]  out_level_r, out_level_nxt;
  logic [otb_pkg::PIX_W-1:0]  out_bin_r, out_bin_nxt;

  // Datapath registers of the threshold search.
  logic [otb_pkg::BIN_W-1:0]  k_r, k_nxt;
  logic [otb_pkg::MOM_W-1:0]  mt_r, mt_nxt;
  logic [otb_pkg::CNT_W-1:0]  w_r, w_nxt;
  logic [otb_pkg::MOM_W-1:0]  m_r, m_nxt;
  logic [otb_pkg::CNT_W-1:0]  nmw_r, nmw_nxt;
  logic [otb_pkg::PROD_W-1:0] p_r, p_nxt;
  logic [otb_pkg::PROD_W-1:0] a_r, a_nxt;
  logic [otb_pkg::PROD_W-1:0] d_r, d_nxt;
  logic [otb_pkg::DEN_W-1:0]  den_r, den_nxt;
  logic [otb_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [otb_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [otb_pkg::QUO_W-1:0]  q_r, q_nxt;
  logic [otb_pkg::DIVC_W-1:0] divc_r, divc_nxt;
  logic                       div_avg_r, div_avg_nxt;
  logic [otb_pkg::QUO_W-1:0]  best_r, best_nxt;
  logic [otb_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [otb_pkg::TIE_W-1:0]  tie_r, tie_nxt;

  // Handshake and shared-unit signals.
  logic                       in_fire;
  logic                       out_fire;
  logic                       out_free;
  logic [otb_pkg::BIN_W-1:0]  rd_idx;
  logic [otb_pkg::CNT_W-1:0]  rd_cnt;
  logic [otb_pkg::MUL_W-1:0]  mul_a;
  logic [otb_pkg::MUL_W-1:0]  mul_b;
  logic [2*otb_pkg::MUL_W-1:0] mult_p;
  logic [otb_pkg::DEN_W:0]    rem_sh;

  // Channel handshakes.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == otb_pkg::S_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.is_threshold    = out_is_thr_r;
  assign out_ch.threshold_level = out_level_r;
  assign out_ch.binary_pixel    = out_bin_r;

  // Single histogram read port: the incoming pixel's bin when idle, else the bin index.
  assign rd_idx = (state_r == otb_pkg::S_IDLE) ? in_ch.pixel[otb_pkg::PIX_W-1 -: otb_pkg::BIN_W]
                                               : k_r;
  assign rd_cnt = bins_r[rd_idx];

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      otb_pkg::S_MT, otb_pkg::S_ACC: begin
        mul_a = otb_pkg::MUL_W'(k_r);
        mul_b = otb_pkg::MUL_W'(rd_cnt);
      end
      otb_pkg::S_MA: begin
        mul_a = mt_r;
        mul_b = otb_pkg::MUL_W'(w_r);
      end
      otb_pkg::S_MB: begin
        mul_a = otb_pkg::MUL_W'(total_r);
        mul_b = m_r;
      end
      otb_pkg::S_DEN: begin
        mul_a = otb_pkg::MUL_W'(w_r);
        mul_b = otb_pkg::MUL_W'(nmw_r);
      end
      otb_pkg::S_SQ0: begin
        mul_a = otb_pkg::MUL_W'(d_r[otb_pkg::HALF_W-1:0]);
        mul_b = otb_pkg::MUL_W'(d_r[otb_pkg::HALF_W-1:0]);
      end
      otb_pkg::S_SQ1: begin
        mul_a = otb_pkg::MUL_W'(d_r[otb_pkg::HALF_W-1:0]);
        mul_b = otb_pkg::MUL_W'(d_r[otb_pkg::PROD_W-1:otb_pkg::HALF_W]);
      end
      otb_pkg::S_SQ2: begin
        mul_a = otb_pkg::MUL_W'(d_r[otb_pkg::PROD_W-1:otb_pkg::HALF_W]);
        mul_b = otb_pkg::MUL_W'(d_r[otb_pkg::PROD_W-1:otb_pkg::HALF_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mult_p = mul_a * mul_b;

  // Restoring divider step: bring down the next dividend bit.
  assign rem_sh = {rem_r, sq_r[otb_pkg::SQ_W-1]};

  // Next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    bins_nxt      = bins_r;
    total_nxt     = total_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r;
    out_is_thr_nxt = out_is_thr_r;
    out_level_nxt = out_level_r;
    out_bin_nxt   = out_bin_r;
    k_nxt         = k_r;
    mt_nxt        = mt_r;
    w_nxt         = w_r;
    m_nxt         = m_r;
    nmw_nxt       = nmw_r;
    p_nxt         = p_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    den_nxt       = den_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    divc_nxt      = divc_r;
    div_avg_nxt   = div_avg_r;
    best_nxt      = best_r;
    sum_nxt       = sum_r;
    tie_nxt       = tie_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Accept pixels: binarize, or count into the histogram.
      otb_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == otb_pkg::KIND_BINARIZE) begin
            out_valid_nxt  = 1'b1;
            out_is_thr_nxt = 1'b0;
            out_level_nxt  = thr_r;
            out_bin_nxt    = (in_ch.pixel <= thr_r) ? otb_pkg::PIX_BLACK : otb_pkg::PIX_WHITE;
          end else begin
            if (total_r < otb_pkg::MAX_PIXELS) begin
              bins_nxt[rd_idx] = rd_cnt + 1'b1;
              total_nxt        = total_r + 1'b1;
            end
            if (in_ch.last) begin
              state_nxt = otb_pkg::S_MT;
              k_nxt     = '0;
              mt_nxt    = '0;
            end
          end
        end
      end

      // Total moment over all bins.
      otb_pkg::S_MT: begin
        mt_nxt = mt_r + mult_p[otb_pkg::MOM_W-1:0];
        k_nxt  = k_r + 1'b1;
        if (k_r == otb_pkg::LAST_BIN) begin
          state_nxt = otb_pkg::S_ACC;
          w_nxt     = '0;
          m_nxt     = '0;
          best_nxt  = '0;
          sum_nxt   = '0;
          tie_nxt   = '0;
        end
      end

      // Cumulative count and moment up to bin k.
      otb_pkg::S_ACC: begin
        w_nxt     = w_r + rd_cnt;
        m_nxt     = m_r + mult_p[otb_pkg::MOM_W-1:0];
        state_nxt = otb_pkg::S_CHK;
      end

      // An empty class on either side gives zero variance.
      otb_pkg::S_CHK: begin
        nmw_nxt = total_r - w_r;
        if ((w_r == '0) || (w_r >= total_r)) begin
          q_nxt     = '0;
          state_nxt = otb_pkg::S_CMP;
        end else begin
          state_nxt = otb_pkg::S_MA;
        end
      end

      otb_pkg::S_MA: begin
        p_nxt     = mult_p[otb_pkg::PROD_W-1:0];
        state_nxt = otb_pkg::S_MB;
      end

      otb_pkg::S_MB: begin
        a_nxt     = p_r;
        p_nxt     = mult_p[otb_pkg::PROD_W-1:0];
        state_nxt = otb_pkg::S_DIF;
      end

      // Absolute difference MT*W - N*M.
      otb_pkg::S_DIF: begin
        d_nxt     = (a_r >= p_r) ? (a_r - p_r) : (p_r - a_r);
        state_nxt = otb_pkg::S_DEN;
      end

      otb_pkg::S_DEN: begin
        p_nxt     = mult_p[otb_pkg::PROD_W-1:0];
        state_nxt = otb_pkg::S_SQ0;
      end

      // Square of the difference from three partial products.
      otb_pkg::S_SQ0: begin
        den_nxt   = p_r[otb_pkg::DEN_W-1:0];
        p_nxt     = mult_p[otb_pkg::PROD_W-1:0];
        state_nxt = otb_pkg::S_SQ1;
      end

      otb_pkg::S_SQ1: begin
        sq_nxt    = otb_pkg::SQ_W'(p_r);
        p_nxt     = mult_p[otb_pkg::PROD_W-1:0];
        state_nxt = otb_pkg::S_SQ2;
      end

      otb_pkg::S_SQ2: begin
        sq_nxt    = sq_r + (otb_pkg::SQ_W'(p_r) << (otb_pkg::HALF_W + 1));
        p_nxt     = mult_p[otb_pkg::PROD_W-1:0];
        state_nxt = otb_pkg::S_SQ3;
      end

      otb_pkg::S_SQ3: begin
        sq_nxt      = sq_r + (otb_pkg::SQ_W'(p_r) << (2 * otb_pkg::HALF_W));
        rem_nxt     = '0;
        divc_nxt    = '0;
        div_avg_nxt = 1'b0;
        state_nxt   = otb_pkg::S_DIV;
      end

      // One quotient bit per cycle.
      otb_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = otb_pkg::DEN_W'(rem_sh - {1'b0, den_r});
          q_nxt   = {q_r[otb_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[otb_pkg::DEN_W-1:0];
          q_nxt   = {q_r[otb_pkg::QUO_W-2:0], 1'b0};
        end
        sq_nxt   = sq_r << 1;
        divc_nxt = divc_r + 1'b1;
        if (divc_r == otb_pkg::DIV_LAST) begin
          state_nxt = div_avg_r ? otb_pkg::S_FIN : otb_pkg::S_CMP;
        end
      end

      // Track the maximum variance and the bins that tie with it.
      otb_pkg::S_CMP: begin
        if (q_r > best_r) begin
          best_nxt = q_r;
          sum_nxt  = otb_pkg::SUM_W'(k_r);
          tie_nxt  = otb_pkg::TIE_W'(1);
        end else if (q_r == best_r) begin
          sum_nxt = sum_r + otb_pkg::SUM_W'(k_r);
          tie_nxt = tie_r + 1'b1;
        end
        if (k_r == otb_pkg::LAST_BIN) begin
          state_nxt = otb_pkg::S_AVG;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = otb_pkg::S_ACC;
        end
      end

      // Threshold = floor(16 * sum / ties), on the same divider.
      otb_pkg::S_AVG: begin
        sq_nxt      = otb_pkg::SQ_W'({sum_r, 4'b0000});
        den_nxt     = otb_pkg::DEN_W'(tie_r);
        rem_nxt     = '0;
        divc_nxt    = '0;
        div_avg_nxt = 1'b1;
        state_nxt   = otb_pkg::S_DIV;
      end

      // Store and emit the threshold, then clear the histogram.
      otb_pkg::S_FIN: begin
        if (out_free) begin
          thr_nxt = (q_r > otb_pkg::QUO_W'(otb_pkg::PIX_WHITE)) ? otb_pkg::PIX_WHITE
                                                               : q_r[otb_pkg::PIX_W-1:0];
          out_valid_nxt  = 1'b1;
          out_is_thr_nxt = 1'b1;
          out_level_nxt  = thr_nxt;
          out_bin_nxt    = otb_pkg::PIX_BLACK;
          for (int i = 0; i < otb_pkg::BINS; i++) begin
            bins_nxt[i] = '0;
          end
          total_nxt = '0;
          state_nxt = otb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = otb_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Histogram, threshold and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < otb_pkg::BINS; i++) begin
        bins_r[i] <= '0;
      end
      total_r     <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bins_r      <= bins_nxt;
      total_r     <= total_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    out_is_thr_r <= out_is_thr_nxt;
    out_level_r  <= out_level_nxt;
    out_bin_r    <= out_bin_nxt;
    k_r          <= k_nxt;
    mt_r         <= mt_nxt;
    w_r          <= w_nxt;
    m_r          <= m_nxt;
    nmw_r        <= nmw_nxt;
    p_r          <= p_nxt;
    a_r          <= a_nxt;
    d_r          <= d_nxt;
    den_r        <= den_nxt;
    sq_r         <= sq_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    divc_r       <= divc_nxt;
    div_avg_r    <= div_avg_nxt;
    best_r       <= best_nxt;
    sum_r        <= sum_nxt;
    tie_r        <= tie_nxt;
  end

  // Input is only taken while the sequencer is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == otb_pkg::S_IDLE))
    else $error("input accepted while the threshold search is running");

  // The pixel total never exceeds the histogram capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= otb_pkg::MAX_PIXELS)
    else $error("pixel total beyond capacity");

  // The divider remainder stays below its divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == otb_pkg::S_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  // Averaging needs at least one tied bin.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == otb_pkg::S_AVG) |-> (tie_r != '0))
    else $error("no bin reached the maximum variance");

  // Finishing the search emits a threshold result and clears the histogram.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == otb_pkg::S_FIN) && out_free) |=>
      (out_valid_r && out_is_thr_r && (total_r == '0) && (state_r == otb_pkg::S_IDLE)))
    else $error("threshold result not issued at the end of the search");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the Otsu threshold binarizer, with its own result predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import otb_pkg::*;

  // One result transaction as the output channel carries it.
  typedef struct packed {
    logic             is_threshold;
    logic [PIX_W-1:0] threshold_level;
    logic [PIX_W-1:0] binary_pixel;
  } result_t;

  // Pixel distributions used to build random images.
  typedef enum int {
    MIX_UNIFORM,
    MIX_BIMODAL,
    MIX_CONSTANT,
    MIX_NARROW
  } pixel_mix_t;

  localparam int PHASE_ITEMS = 600;
  localparam int REPORT_MAX  = 10;

  logic clk;
  logic rst_n;

  otb_in_if  in_ch ();
  otb_out_if out_ch ();

  otsu_threshold_binarizer DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted copy of the histogram and the stored threshold.
  logic [CNT_W-1:0] hist_bins [BINS];
  logic [CNT_W-1:0] hist_total;
  logic [PIX_W-1:0] stored_level;
  result_t          expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;
  int mismatches    = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #250_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Counts a failure and reports the first few of them.
  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%t: %s", $realtime, msg);
  endfunction

  // Otsu threshold of the predicted histogram, in exact integer arithmetic.
  function automatic logic [PIX_W-1:0] otsu_level();
    logic [63:0]  n, mt, w, m, a, b, d, best, tie_sum, tie_cnt, t;
    logic [127:0] sq, den;
    logic [63:0]  var_k [BINS];
    n       = 64'(hist_total);
    mt      = '0;
    w       = '0;
    m       = '0;
    best    = '0;
    tie_sum = '0;
    tie_cnt = '0;
    for (int k = 0; k < BINS; k++) mt += 64'(k) * 64'(hist_bins[k]);
    // Between-class variance for each split point; empty splits count as zero.
    for (int k = 0; k < BINS; k++) begin
      w += 64'(hist_bins[k]);
      m += 64'(k) * 64'(hist_bins[k]);
      if (w == 0 || w >= n) begin
        var_k[k] = '0;
      end else begin
        a        = mt * w;
        b        = n * m;
        d        = (a >= b) ? a - b : b - a;
        sq       = 128'(d) * 128'(d);
        den      = 128'(w * (n - w));
        var_k[k] = 64'(sq / den);
      end
      if (var_k[k] > best) best = var_k[k];
    end
    // Average the bins that reach the maximum.
    for (int k = 0; k < BINS; k++) begin
      if (var_k[k] == best) begin
        tie_cnt++;
        tie_sum += 64'(k);
      end
    end
    t = (64'd256 * tie_sum) / (64'(BINS) * tie_cnt);
    if (t > 64'(PIX_WHITE)) t = 64'(PIX_WHITE);
    return t[PIX_W-1:0];
  endfunction

  // Applies one accepted input transaction to the predicted state.
  function automatic void account_pixel(logic kind, logic [PIX_W-1:0] pixel, logic last);
    result_t r;
    if (kind == KIND_BINARIZE) begin
      r.is_threshold    = 1'b0;
      r.threshold_level = stored_level;
      r.binary_pixel    = (pixel <= stored_level) ? PIX_BLACK : PIX_WHITE;
      expected_results.push_back(r);
    end else begin
      // A full histogram stops counting, but last still closes the image.
      if (hist_total < MAX_PIXELS) begin
        hist_bins[pixel[PIX_W-1 -: BIN_W]]++;
        hist_total++;
      end
      if (last) begin
        stored_level = otsu_level();
        for (int k = 0; k < BINS; k++) hist_bins[k] = '0;
        hist_total        = '0;
        r.is_threshold    = 1'b1;
        r.threshold_level = stored_level;
        r.binary_pixel    = PIX_BLACK;
        expected_results.push_back(r);
      end
    end
  endfunction

  // Offers one input transaction, with random idle cycles ahead of it.
  task automatic send_item(logic kind, logic [PIX_W-1:0] pixel, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.pixel <= pixel;
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    account_pixel(kind, pixel, last);
  endtask

  // Draws a pixel from the given distribution.
  function automatic logic [PIX_W-1:0] draw_pixel(pixel_mix_t mix, int c0, int c1, int spread);
    int center;
    int v;
    case (mix)
      MIX_UNIFORM:  return PIX_W'($urandom_range(255));
      MIX_CONSTANT: return PIX_W'(c0);
      MIX_BIMODAL:  center = $urandom_range(1) ? c0 : c1;
      default:      center = c0;
    endcase
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.is_threshold, out_ch.threshold_level, out_ch.binary_pixel};
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result: is_threshold=%0d level=%0d pixel=%0d",
                             got.is_threshold, got.threshold_level, got.binary_pixel));
      end else begin
        want = expected_results.pop_front();
        if (got.is_threshold !== want.is_threshold ||
            got.threshold_level !== want.threshold_level ||
            got.binary_pixel !== want.binary_pixel) begin
          note_error($sformatf({"mismatch: expected is_threshold=%0d level=%0d pixel=%0d,",
                                " got is_threshold=%0d level=%0d pixel=%0d"},
                               want.is_threshold, want.threshold_level, want.binary_pixel,
                               got.is_threshold, got.threshold_level, got.binary_pixel));
        end
      end
    end
  end

  // The threshold is zero after reset, so only pixel 0 is black; last on a binarize is ignored.
  task automatic test_binarize_at_reset();
    send_item(KIND_BINARIZE, 8'd0, 1'b0);
    send_item(KIND_BINARIZE, 8'd1, 1'b0);
    send_item(KIND_BINARIZE, 8'd255, 1'b1);
  endtask

  // Images whose variances are all zero: every bin ties and all are averaged.
  task automatic test_flat_variance();
    send_item(KIND_COUNT, 8'd77, 1'b1);
    send_item(KIND_COUNT, 8'd200, 1'b0);
    send_item(KIND_COUNT, 8'd200, 1'b0);
    send_item(KIND_COUNT, 8'd200, 1'b1);
    send_item(KIND_BINARIZE, 8'd120, 1'b0);
    send_item(KIND_BINARIZE, 8'd121, 1'b0);
  endtask

  // Pixels on the bin boundaries and the ends of the range.
  task automatic test_bin_edges();
    logic [PIX_W-1:0] edges [8] = '{8'd0, 8'd15, 8'd16, 8'd127, 8'd128, 8'd239, 8'd240, 8'd255};
    foreach (edges[i]) send_item(KIND_COUNT, edges[i], i == 7);
    send_item(KIND_BINARIZE, 8'd127, 1'b0);
    send_item(KIND_BINARIZE, 8'd128, 1'b0);
  endtask

  // Mostly well-formed images with random content, some noise and a few broken images.
  task automatic test_random_images(int n_items);
    int         sent;
    int         len;
    int         c0;
    int         c1;
    int         spread;
    pixel_mix_t mix;
    sent = 0;
    while (sent < n_items) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(300, 64) : $urandom_range(1, 24);
      mix    = pixel_mix_t'($urandom_range(3));
      c0     = $urandom_range(255);
      c1     = $urandom_range(255);
      spread = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(KIND_BINARIZE, PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end
        // Now and then the closing last is dropped, merging two images.
        send_item(KIND_COUNT, draw_pixel(mix, c0, c1, spread),
                  (i == len - 1) && ($urandom_range(19) != 0));
        sent++;
      end
      repeat ($urandom_range(8)) begin
        send_item(KIND_BINARIZE, PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // The receiver holds off for longer than a threshold search while pixels keep coming,
  // so the threshold result waits and the binarize transactions behind it stall.
  task automatic test_output_stall();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    stall_left    = 2500;
    for (int i = 0; i < 5; i++) send_item(KIND_COUNT, PIX_W'($urandom_range(255)), i == 4);
    repeat (20) send_item(KIND_BINARIZE, PIX_W'($urandom_range(255)), 1'b0);
    send_idle_pct = saved_idle;
  endtask

  // Reset, then the tests in turn; the random images run under three idling patterns.
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_COUNT;
    in_ch.pixel  = '0;
    in_ch.last   = 1'b0;
    for (int k = 0; k < BINS; k++) hist_bins[k] = '0;
    hist_total   = '0;
    stored_level = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 53;
    test_binarize_at_reset();
    test_flat_variance();
    test_bin_edges();
    test_random_images(PHASE_ITEMS);
    test_output_stall();

    send_idle_pct = 53;
    recv_idle_pct = 21;
    test_random_images(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_images(PHASE_ITEMS);

    // Drain the remaining results, then let the bench go quiet before reporting.
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/otb_pkg.sv
hw/rtl/otb_if.sv
hw/rtl/otsu_threshold_binarizer.sv
test/testbench.sv
